### rtl/core/hrcd_pkg.sv
`timescale 1ns / 1ps
package hrcd_pkg;

   localparam int CHUNK_LEN_BITS_DEF = 32;
   localparam int TE_LEN = 17;
   localparam int CK_LEN = 7;

   localparam logic [1:0] TOP_HEADER  = 2'd0;
   localparam logic [1:0] TOP_PLAIN   = 2'd1;
   localparam logic [1:0] TOP_CHUNKED = 2'd2;

   localparam logic [1:0] ST_SKIP   = 2'd0;
   localparam logic [1:0] ST_DIGITS = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;

   localparam logic [3:0] CK_PREFIX = 4'd0;
   localparam logic [3:0] CK_ZERO   = 4'd1;
   localparam logic [3:0] CK_X      = 4'd2;
   localparam logic [3:0] CK_DIGITS = 4'd3;
   localparam logic [3:0] CK_REST   = 4'd4;
   localparam logic [3:0] CK_DATA   = 4'd5;
   localparam logic [3:0] CK_SKIP1  = 4'd6;
   localparam logic [3:0] CK_SKIP2  = 4'd7;
   localparam logic [3:0] CK_END    = 4'd8;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_NOCRLF = 2'd1;
   localparam logic [1:0] ERR_STATUS = 2'd2;
   localparam logic [1:0] ERR_NOSEP  = 2'd3;

   localparam logic [7:0] CHR_CR = 8'h0d;
   localparam logic [7:0] CHR_LF = 8'h0a;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_response;
   } req_word_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  body_byte;
      logic [15:0] status_code;
      logic        status_ok;
      logic [1:0]  error_code;
      logic        was_chunked;
      logic        chunk_cut_short;
      logic        final_item;
   } rsp_word_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: return "t";   5'd1: return "r";   5'd2: return "a";
         5'd3: return "n";   5'd4: return "s";   5'd5: return "f";
         5'd6: return "e";   5'd7: return "r";   5'd8: return "-";
         5'd9: return "e";   5'd10: return "n";  5'd11: return "c";
         5'd12: return "o";  5'd13: return "d";  5'd14: return "i";
         5'd15: return "n";  5'd16: return "g";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ck_char(input logic [2:0] i);
      case (i)
         3'd0: return "c"; 3'd1: return "h"; 3'd2: return "u"; 3'd3: return "n";
         3'd4: return "k"; 3'd5: return "e"; 3'd6: return "d";
         default: return 8'h00;
      endcase
   endfunction

endpackage

### rtl/core/http_response_chunked_decoder.sv
`timescale 1ns / 1ps
// Streaming HTTP/1.1 response decoder. One response byte is taken per cycle unless the
// result queue lacks room for its words; the body comes out one word per body byte,
// dechunked when the first transfer-encoding header names chunked; the byte flagged
// end_of_response also yields a summary word (status, ok, chunked, cut-short, error)
// after any body word it causes, and all parse state then returns to reset for the next
// response. A byte passes through the input register and then into the two-entry result
// queue; a byte that yields both a body word and a summary word waits until the queue,
// after any word read out in that cycle, is empty.
module http_response_chunked_decoder
   import hrcd_pkg::*;
#(
   parameter int CHUNK_LEN_BITS = CHUNK_LEN_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam logic [CHUNK_LEN_BITS-1:0] LEN_MAX = '1;

   logic         inv_ff;
   req_word_type inw_ff;
   logic [1:0]  top_ff, top_in;
   logic [23:0] recent_ff, recent_in;
   logic crlf_ff, crlf_in, space_ff, space_in;
   logic [1:0]  bas_ff, bas_in, stp_ff, stp_in;
   logic [15:0] acc_ff, acc_in;
   logic [4:0]  hmi_ff, hmi_in;
   logic hfound_ff, hfound_in, teopen_ff, teopen_in;
   logic [2:0]  cmi_ff, cmi_in;
   logic cflag_ff, cflag_in;
   logic [3:0]  ckp_ff, ckp_in;
   logic [CHUNK_LEN_BITS-1:0] rem_ff, rem_in;
   logic sizecr_ff, sizecr_in;

   rsp_word_type q0_ff, q1_ff;
   logic [1:0]   qn_ff;
   logic         emit_body, emit_sum, fire;
   rsp_word_type body_w, sum_w;

   // process only when the queue, after this cycle's read, has room for every word the byte yields
   logic [1:0] qn_after;
   assign qn_after = qn_ff - {1'b0, (rsp_valid & rsp_ready)};
   assign fire = inv_ff && (qn_after == 2'd0 ||
                 (qn_after == 2'd1 && !(emit_body && emit_sum)));
   assign req_ready = !inv_ff || fire;

   always_comb begin
      logic [7:0] b, lb, prev;
      logic [16:0] v;
      logic [4:0] d;
      logic isdig;
      b = inw_ff.data_byte;
      lb = to_lower(b);
      prev = recent_ff[7:0];
      top_in = top_ff; crlf_in = crlf_ff; space_in = space_ff; bas_in = bas_ff;
      stp_in = stp_ff; acc_in = acc_ff; hmi_in = hmi_ff; hfound_in = hfound_ff;
      teopen_in = teopen_ff; cmi_in = cmi_ff; cflag_in = cflag_ff; ckp_in = ckp_ff;
      rem_in = rem_ff; sizecr_in = sizecr_ff;
      emit_body = 1'b0;
      isdig = b >= "0" && b <= "9";
      v = '0;
      if (isdig) d = {1'b0, b[3:0]};
      else if (lb >= "a" && lb <= "f") d = {1'b0, lb[3:0]} + 5'd9;
      else d = 5'h10;

      if (b == CHR_LF && prev == CHR_CR) crlf_in = 1'b1;
      if (space_ff) begin
         if (bas_ff != 2'd3) bas_in = bas_ff + 2'd1;
         case (stp_ff)
            ST_SKIP: begin
               if (b == " " || (b >= 8'h09 && b <= 8'h0d)) stp_in = ST_SKIP;
               else if (b == "+") stp_in = ST_DIGITS;
               else if (isdig) begin
                  acc_in = {12'd0, b[3:0]}; stp_in = ST_DIGITS;
               end else stp_in = ST_DONE;
            end
            ST_DIGITS: begin
               if (isdig) begin
                  v = {1'b0, acc_ff} * 17'd10 + {13'd0, b[3:0]};
                  acc_in = (v > 17'hffff || acc_ff > 16'd6553) ? 16'hffff : v[15:0];
               end else stp_in = ST_DONE;
            end
            default: ;
         endcase
      end else if (b == " ") space_in = 1'b1;

      case (top_ff)
         TOP_HEADER: begin
            if (!hfound_ff) begin
               if (lb == te_char(hmi_ff)) begin
                  if (hmi_ff == 5'(TE_LEN - 1)) begin
                     hfound_in = 1'b1; teopen_in = 1'b1; hmi_in = '0;
                  end else hmi_in = hmi_ff + 5'd1;
               end else hmi_in = (lb == "t") ? 5'd1 : 5'd0;
            end else if (teopen_ff) begin
               if (b == CHR_LF && prev == CHR_CR) teopen_in = 1'b0;
               else if (!cflag_ff) begin
                  if (lb == ck_char(cmi_ff)) begin
                     if (cmi_ff == 3'(CK_LEN - 1)) begin
                        cflag_in = 1'b1; cmi_in = '0;
                     end else cmi_in = cmi_ff + 3'd1;
                  end else cmi_in = (lb == "c") ? 3'd1 : 3'd0;
               end
            end
            if (b == CHR_LF && recent_ff == 24'h0d0a0d)
               top_in = cflag_in ? TOP_CHUNKED : TOP_PLAIN;
         end
         TOP_PLAIN: emit_body = 1'b1;
         default: begin
            case (ckp_ff)
               CK_DATA: begin
                  rem_in = rem_ff - 1'b1;
                  if (rem_ff == CHUNK_LEN_BITS'(1)) ckp_in = CK_SKIP1;
                  emit_body = 1'b1;
               end
               CK_SKIP1: ckp_in = CK_SKIP2;
               CK_SKIP2: begin
                  ckp_in = CK_PREFIX; rem_in = '0; sizecr_in = 1'b0;
               end
               CK_END: ;
               default: begin
                  if (b == CHR_LF && sizecr_ff) begin
                     sizecr_in = 1'b0;
                     ckp_in = (rem_ff == '0) ? CK_END : CK_DATA;
                  end else begin
                     sizecr_in = (b == CHR_CR);
                     if ((ckp_ff == CK_PREFIX) && (b == " " || b == 8'h09)) ;
                     else if (ckp_ff == CK_PREFIX && b == "0") ckp_in = CK_ZERO;
                     else if (ckp_ff == CK_ZERO && lb == "x") ckp_in = CK_X;
                     else if (ckp_ff == CK_REST) ;
                     else if (!d[4]) begin
                        ckp_in = CK_DIGITS;
                        if (rem_ff[CHUNK_LEN_BITS-1 -: 4] != 4'd0) rem_in = LEN_MAX;
                        else rem_in = {rem_ff[CHUNK_LEN_BITS-5:0], d[3:0]};
                     end else ckp_in = CK_REST;
                  end
               end
            endcase
         end
      endcase
      emit_sum = inw_ff.end_of_response;
   end

   always_comb begin
      body_w = '0;
      body_w.body_byte = inw_ff.data_byte;
      sum_w = '0;
      sum_w.item_kind = 1'b1;
      sum_w.final_item = 1'b1;
      sum_w.chunk_cut_short = (top_ff == TOP_CHUNKED) && (ckp_in == CK_DATA);
      if (!crlf_in) sum_w.error_code = ERR_NOCRLF;
      else if (!space_in || bas_in != 2'd3) sum_w.error_code = ERR_STATUS;
      else if (top_in == TOP_HEADER) sum_w.error_code = ERR_NOSEP;
      else sum_w.error_code = ERR_NONE;
      if (sum_w.error_code == ERR_NONE || sum_w.error_code == ERR_NOSEP)
         sum_w.status_code = acc_in;
      sum_w.status_ok = sum_w.error_code == ERR_NONE && sum_w.status_code >= 16'd200
                        && sum_w.status_code <= 16'd299;
      sum_w.was_chunked = sum_w.error_code == ERR_NONE && top_in == TOP_CHUNKED;
   end

   assign rsp_valid = qn_ff != 2'd0;
   assign rsp_data  = q0_ff;

   always_ff @(posedge clock) begin
      logic [1:0] n;
      rsp_word_type a, c;
      if (req_ready) inw_ff <= req_data;
      n = qn_after;
      a = q0_ff; c = q1_ff;
      if (rsp_valid && rsp_ready) a = q1_ff;
      if (fire && emit_body) begin
         if (n == 2'd0) a = body_w; else c = body_w;
         n = n + 2'd1;
      end
      if (fire && emit_sum) begin
         if (n == 2'd0) a = sum_w; else c = sum_w;
         n = n + 2'd1;
      end
      q0_ff <= a; q1_ff <= c;
      if (reset) begin
         inv_ff <= 1'b0; qn_ff <= '0;
      end else begin
         qn_ff <= n;
         if (req_ready) inv_ff <= req_valid;
      end
      if (reset || (fire && emit_sum)) begin
         top_ff <= TOP_HEADER; recent_ff <= '0; crlf_ff <= 1'b0; space_ff <= 1'b0;
         bas_ff <= '0; stp_ff <= ST_SKIP; acc_ff <= '0; hmi_ff <= '0;
         hfound_ff <= 1'b0; teopen_ff <= 1'b0; cmi_ff <= '0; cflag_ff <= 1'b0;
         ckp_ff <= CK_PREFIX; rem_ff <= '0; sizecr_ff <= 1'b0;
      end else if (fire) begin
         top_ff <= top_in; recent_ff <= {recent_ff[15:0], inw_ff.data_byte};
         crlf_ff <= crlf_in; space_ff <= space_in; bas_ff <= bas_in; stp_ff <= stp_in;
         acc_ff <= acc_in; hmi_ff <= hmi_in; hfound_ff <= hfound_in;
         teopen_ff <= teopen_in; cmi_ff <= cmi_in; cflag_ff <= cflag_in;
         ckp_ff <= ckp_in; rem_ff <= rem_in; sizecr_ff <= sizecr_in;
      end
   end

endmodule
